// ===== src/rjag_pkg.sv =====
// Shared types and constants for the multi-ring journal address generator.
package rjag_pkg;

    localparam int ADDR_W      = 16;
    localparam int SLOT_W      = 8;
    localparam int LOG_W       = 2;
    localparam int NUM_LOGS    = 4;
    localparam int SIZE_W      = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    localparam logic [SIZE_W-1:0] TRIP_BYTES_DEF  = 8'd32;
    localparam logic [SIZE_W-1:0] ACCEL_BYTES_DEF = 8'd16;
    localparam logic [SLOT_W-1:0] CAP_RESET       = 8'd16;
    localparam logic [SLOT_W-1:0] SLOT_RESET      = 8'hFF;
    localparam logic [LOG_W-1:0]  LOG_ACCEL       = 2'd3;

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_LOCATE = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE = 3'd0,
        REG_CAP0 = 3'd1,
        REG_CAP1 = 3'd2,
        REG_CAP2 = 3'd3,
        REG_CAP3 = 3'd4
    } reg_idx_t;

    typedef struct packed {
        logic [7:0]       back_count;
        logic [LOG_W-1:0] log_sel;
        op_t              op;
    } item_t;

    typedef struct packed {
        logic [ADDR_W-1:0]                base;
        logic [NUM_LOGS-1:0][SLOT_W-1:0]  cap;
    } cfg_t;

endpackage

// ===== src/multi_ring_journal_address_gen_top.sv =====
// Top level of the multi-ring journal address generator.
// An accepted request goes into the input register; its result is then loaded into the
// result register, from which the receiver takes it.
// Throughput: one request per cycle while results are taken; each append updates its log's pointer register.
// An input register and a result register separate the two streams.
// Reset is synchronous and active low: pointers go to 255, base to 0, capacities to 16.
module multi_ring_journal_address_gen_top #(
    parameter logic [7:0] TRIP_ITEM_BYTES  = rjag_pkg::TRIP_BYTES_DEF,
    parameter logic [7:0] ACCEL_ITEM_BYTES = rjag_pkg::ACCEL_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rjag_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [rjag_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // operation [0], log_select [2:1], back_count [10:3], zero [15:11]
    input  logic [rjag_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // mem_address [15:0], slot_index [23:16]
    output logic [rjag_pkg::OUT_TDATA_W-1:0]    m_tdata
);
    import rjag_pkg::*;

    cfg_t  cfg_reg;
    item_t item_reg;
    logic  in_valid_reg;
    logic  m_valid_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;
    logic  advance;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] mem_address;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base <= '0;
            cfg_reg.cap  <= {NUM_LOGS{CAP_RESET}};
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BASE: cfg_reg.base   <= cfg_wr_data;
                REG_CAP0: cfg_reg.cap[0] <= cfg_wr_data[SLOT_W-1:0];
                REG_CAP1: cfg_reg.cap[1] <= cfg_wr_data[SLOT_W-1:0];
                REG_CAP2: cfg_reg.cap[2] <= cfg_wr_data[SLOT_W-1:0];
                REG_CAP3: cfg_reg.cap[3] <= cfg_wr_data[SLOT_W-1:0];
                default: ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = aresetn && (!in_valid_reg || advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.op         <= op_t'(s_tdata[0]);
            item_reg.log_sel    <= s_tdata[2:1];
            item_reg.back_count <= s_tdata[10:3];
        end
    end

    rjag_ptr u_ptr (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item    (item_reg),
        .step    (advance),
        .cap     (cfg_reg.cap),
        .slot    (slot)
    );

    rjag_addr #(
        .TRIP_ITEM_BYTES  (TRIP_ITEM_BYTES),
        .ACCEL_ITEM_BYTES (ACCEL_ITEM_BYTES)
    ) u_addr (
        .cfg         (cfg_reg),
        .log_sel     (item_reg.log_sel),
        .slot        (slot),
        .mem_address (mem_address)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {slot, mem_address};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== src/rjag_ptr.sv =====
// Newest-slot pointers for the four logs and the slot selection for one request.
module rjag_ptr (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  rjag_pkg::item_t                       item,
    input  logic                                  step,
    input  logic [rjag_pkg::NUM_LOGS-1:0][7:0]    cap,
    output logic [rjag_pkg::SLOT_W-1:0]           slot
);
    import rjag_pkg::*;

    logic [NUM_LOGS-1:0][SLOT_W-1:0] newest_reg, newest_next;
    logic [SLOT_W-1:0] cur, cap_sel, inc, wrapped, located;

    always_comb begin
        cur     = newest_reg[item.log_sel];
        cap_sel = cap[item.log_sel];
        inc     = cur + 8'd1;
        wrapped = (inc >= cap_sel) ? '0 : inc;
        // When the count reaches past slot 0 the walk continues from the top of the ring.
        if (item.back_count <= cur) begin
            located = cur - item.back_count;
        end else begin
            located = cur + cap_sel - item.back_count;
        end
        slot        = (item.op == OP_APPEND) ? wrapped : located;
        newest_next = newest_reg;
        if (step && item.op == OP_APPEND) begin
            newest_next[item.log_sel] = wrapped;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            newest_reg <= {NUM_LOGS{SLOT_RESET}};
        end else begin
            newest_reg <= newest_next;
        end
    end

endmodule

// ===== src/rjag_addr.sv =====
// Region start table and slot byte address for the four logs.
module rjag_addr #(
    parameter logic [7:0] TRIP_ITEM_BYTES  = rjag_pkg::TRIP_BYTES_DEF,
    parameter logic [7:0] ACCEL_ITEM_BYTES = rjag_pkg::ACCEL_BYTES_DEF
) (
    input  rjag_pkg::cfg_t                     cfg,
    input  logic [rjag_pkg::LOG_W-1:0]         log_sel,
    input  logic [rjag_pkg::SLOT_W-1:0]        slot,
    output logic [rjag_pkg::ADDR_W-1:0]        mem_address
);
    import rjag_pkg::*;

    logic [NUM_LOGS-1:0][ADDR_W-1:0] region_start;
    logic [8:0]        sum01;
    logic [9:0]        sum012;
    logic [17:0]       off1, off2, off3;
    logic [SIZE_W-1:0] item_size;
    logic [ADDR_W-1:0] slot_off;

    // Every log before the selected one holds trip items, so its region start is a scaled sum.
    always_comb begin
        sum01           = 9'(cfg.cap[0]) + 9'(cfg.cap[1]);
        sum012          = 10'(sum01) + 10'(cfg.cap[2]);
        off1            = 18'(cfg.cap[0]) * 18'(TRIP_ITEM_BYTES);
        off2            = 18'(sum01) * 18'(TRIP_ITEM_BYTES);
        off3            = 18'(sum012) * 18'(TRIP_ITEM_BYTES);
        region_start[0] = cfg.base;
        region_start[1] = cfg.base + off1[ADDR_W-1:0];
        region_start[2] = cfg.base + off2[ADDR_W-1:0];
        region_start[3] = cfg.base + off3[ADDR_W-1:0];
    end

    always_comb begin
        item_size   = (log_sel == LOG_ACCEL) ? ACCEL_ITEM_BYTES : TRIP_ITEM_BYTES;
        slot_off    = 16'(item_size) * 16'(slot);
        mem_address = region_start[log_sel] + slot_off;
    end

endmodule

// ===== src/rjag_chk.sv =====
// Port-level checker for the journal address generator, bound to the top level.
module rjag_chk (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [rjag_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    // A stalled result keeps its value.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // No result is pending right after reset.
    a_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

    // The input side only stalls when both registers are full.
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty result register");

    // A result appearing on an empty output must come from a request accepted into the input register.
    a_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without matching request");

endmodule

bind multi_ring_journal_address_gen_top rjag_chk u_chk (.*);

// ===== sim/tb_multi_ring_journal_address_gen_top.sv =====
// Self-checking testbench for the multi-ring journal address generator.
`timescale 1ns / 1ps

module tb_multi_ring_journal_address_gen_top;
    import rjag_pkg::*;

    localparam int                 CYCLE_LIMIT  = 300000;
    localparam int                 LONG_HOLD    = 200;
    localparam int                 SETTLE       = 4;
    localparam int                 MAX_PRINTS   = 20;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef struct {
        logic [ADDR_W-1:0] mem_address;
        logic [SLOT_W-1:0] slot_index;
    } slot_result_t;

    logic                   aclk        = 1'b0;
    logic                   aresetn     = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_addr    = REG_BASE;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_tvalid    = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata     = '0;
    logic                   m_tvalid;
    logic                   m_tready    = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Testbench copy of the block's registers and newest-slot pointers.
    logic [ADDR_W-1:0] base_mirror = '0;
    logic [SLOT_W-1:0] cap_mirror[NUM_LOGS]    = '{CAP_RESET, CAP_RESET, CAP_RESET, CAP_RESET};
    logic [SLOT_W-1:0] newest_mirror[NUM_LOGS] = '{SLOT_RESET, SLOT_RESET, SLOT_RESET, SLOT_RESET};

    item_t        pending_requests[$];
    slot_result_t expected_slots[$];

    int  error_count   = 0;
    int  checked_count = 0;
    int  append_count  = 0;
    int  locate_count  = 0;
    int  write_count   = 0;
    int  cycle_count   = 0;
    int  send_gap      = 0;
    int  ready_gap     = 0;
    int  hold_left     = 0;
    bit  long_hold_req = 1'b0;
    bit  quiet_tail    = 1'b0;

    multi_ring_journal_address_gen_top u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic report_mismatch(string msg);
        if (error_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Computes the slot and byte address a request selects, advancing the pointer on append.
    function automatic slot_result_t predict_slot_access(item_t req);
        slot_result_t      res;
        logic [SLOT_W-1:0] cur;
        logic [SLOT_W-1:0] cap;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] region;
        logic [ADDR_W-1:0] item_bytes;
        cur = newest_mirror[req.log_sel];
        cap = cap_mirror[req.log_sel];
        if (req.op == OP_APPEND) begin
            slot = cur + 8'd1;
            if (slot >= cap) slot = '0;
            newest_mirror[req.log_sel] = slot;
        end else begin
            slot = cur + cap - req.back_count;
            if (req.back_count <= cur) slot = slot - cap;
        end
        region = base_mirror;
        for (int i = 0; i < NUM_LOGS; i++) begin
            if (i < req.log_sel) region = region + 16'(TRIP_BYTES_DEF) * 16'(cap_mirror[i]);
        end
        item_bytes = (req.log_sel == LOG_ACCEL) ? 16'(ACCEL_BYTES_DEF) : 16'(TRIP_BYTES_DEF);
        res.mem_address = region + item_bytes * 16'(slot);
        res.slot_index  = slot;
        return res;
    endfunction

    // Request driver: holds a request until it is taken, idles in short random bursts.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                send_gap = $urandom_range(0, 5);
                s_tvalid <= 1'b0;
            end else if (pending_requests.size() > 0) begin
                s_tdata  <= IN_TDATA_W'(pending_requests.pop_front());
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, plus one long hold-off on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_left = LONG_HOLD - 1;
            m_tready <= 1'b0;
        end else if (ready_gap > 0) begin
            ready_gap--;
            m_tready <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            ready_gap = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Monitor: checks each result against the oldest prediction, then predicts new requests.
    always @(posedge aclk) begin
        slot_result_t want;
        item_t        req;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (expected_slots.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_tdata));
                end else begin
                    want = expected_slots.pop_front();
                    checked_count++;
                    if (m_tdata[15:0] !== want.mem_address)
                        report_mismatch($sformatf("mem_address %h, predicted %h",
                                                  m_tdata[15:0], want.mem_address));
                    if (m_tdata[23:16] !== want.slot_index)
                        report_mismatch($sformatf("slot_index %0d, predicted %0d",
                                                  m_tdata[23:16], want.slot_index));
                end
            end
            if (s_tvalid && s_tready) begin
                req = item_t'(s_tdata[$bits(item_t)-1:0]);
                if (req.op == OP_APPEND) append_count++;
                else locate_count++;
                expected_slots.push_back(predict_slot_access(req));
            end
        end
    end

    function automatic item_t make_request(op_t op, logic [LOG_W-1:0] log_sel,
                                           logic [7:0] back_count);
        item_t req;
        req.op         = op;
        req.log_sel    = log_sel;
        req.back_count = back_count;
        return req;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= value;
        case (idx)
            REG_BASE: base_mirror   = value;
            REG_CAP0: cap_mirror[0] = value[7:0];
            REG_CAP1: cap_mirror[1] = value[7:0];
            REG_CAP2: cap_mirror[2] = value[7:0];
            REG_CAP3: cap_mirror[3] = value[7:0];
            default: ;
        endcase
        write_count++;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic set_layout(logic [15:0] base, logic [7:0] c0, logic [7:0] c1,
                              logic [7:0] c2, logic [7:0] c3);
        write_reg(REG_BASE, base);
        write_reg(REG_CAP0, {8'h00, c0});
        write_reg(REG_CAP1, {8'h00, c1});
        write_reg(REG_CAP2, {8'h00, c2});
        write_reg(REG_CAP3, {8'h00, c3});
    endtask

    task automatic wait_idle();
        do @(posedge aclk);
        while (pending_requests.size() != 0 || s_tvalid || expected_slots.size() != 0);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Queues random requests; focus_log < 0 spreads them evenly over the logs.
    task automatic queue_random(int n, int append_pct, int focus_log);
        item_t             req;
        logic [LOG_W-1:0]  log_sel;
        repeat (n) begin
            if (focus_log >= 0 && $urandom_range(0, 99) < 85) log_sel = focus_log[LOG_W-1:0];
            else log_sel = LOG_W'($urandom_range(0, NUM_LOGS - 1));
            req = make_request(($urandom_range(0, 99) < append_pct) ? OP_APPEND : OP_LOCATE,
                               log_sel, 8'($urandom_range(0, 255)));
            // Half the locates draw a count no larger than the ring's capacity; the rest draw any 8-bit count.
            if (req.op == OP_LOCATE && $urandom_range(0, 1) == 0)
                req.back_count = 8'($urandom_range(0, cap_mirror[log_sel]));
            pending_requests.push_back(req);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Reset layout: a locate before any append returns the reset pointer of 255.
        pending_requests.push_back(make_request(OP_LOCATE, 2'd0, 8'd0));
        pending_requests.push_back(make_request(OP_LOCATE, 2'd3, 8'd255));
        for (int i = 0; i < NUM_LOGS; i++)
            pending_requests.push_back(make_request(OP_APPEND, i[1:0], 8'hFF));
        pending_requests.push_back(make_request(OP_LOCATE, 2'd0, 8'd0));
        pending_requests.push_back(make_request(OP_LOCATE, 2'd0, 8'd1));
        pending_requests.push_back(make_request(OP_LOCATE, 2'd0, 8'd16));
        pending_requests.push_back(make_request(OP_LOCATE, 2'd0, 8'd255));
        pending_requests.push_back(make_request(OP_APPEND, 2'd3, 8'h00));
        pending_requests.push_back(make_request(OP_LOCATE, 2'd3, 8'd1));
        wait_idle();

        // A zero capacity makes appends stick at slot 0; a write to a spare index is ignored.
        write_reg(REG_CAP0, 16'h0000);
        write_reg(REG_UNUSED, 16'hABCD);
        pending_requests.push_back(make_request(OP_APPEND, 2'd0, 8'd0));
        pending_requests.push_back(make_request(OP_APPEND, 2'd0, 8'd0));
        pending_requests.push_back(make_request(OP_LOCATE, 2'd0, 8'd0));
        pending_requests.push_back(make_request(OP_LOCATE, 2'd0, 8'd3));
        pending_requests.push_back(make_request(OP_LOCATE, 2'd1, 8'd0));
        wait_idle();

        // Largest layout at the top of memory, so every address sum wraps.
        set_layout(16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255);
        pending_requests.push_back(make_request(OP_APPEND, 2'd3, 8'd0));
        pending_requests.push_back(make_request(OP_LOCATE, 2'd3, 8'd0));
        pending_requests.push_back(make_request(OP_LOCATE, 2'd2, 8'd128));
        pending_requests.push_back(make_request(OP_APPEND, 2'd2, 8'd0));
        pending_requests.push_back(make_request(OP_LOCATE, 2'd2, 8'd255));
        wait_idle();

        // Random traffic; the receiver stalls for a long stretch early in this phase.
        set_layout(16'h0100, 8'd16, 8'd16, 8'd16, 8'd16);
        queue_random(150, 50, -1);
        long_hold_req = 1'b1;
        wait_idle();

        set_layout(16'h0000, 8'd1, 8'd1, 8'd1, 8'd1);
        queue_random(120, 50, -1);
        wait_idle();

        // Enough appends to one log to carry its pointer around the largest ring.
        set_layout(16'hFFF0, 8'd255, 8'd255, 8'd255, 8'd255);
        queue_random(400, 80, 3);
        wait_idle();

        repeat (3) begin
            set_layout(16'($urandom_range(0, 65535)), 8'($urandom_range(1, 255)),
                       8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                       8'($urandom_range(1, 255)));
            queue_random(110, 55, $urandom_range(0, 1) ? -1 : $urandom_range(0, 3));
            wait_idle();
        end

        set_layout(16'($urandom_range(0, 65535)), 8'($urandom_range(1, 8)),
                   8'($urandom_range(1, 8)), 8'($urandom_range(1, 8)),
                   8'($urandom_range(1, 8)));
        queue_random(100, 60, -1);
        wait_idle();

        // Final stretch runs back to back with no idling on either side.
        set_layout(16'($urandom_range(0, 65535)), 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                   8'($urandom_range(1, 255)));
        quiet_tail = 1'b1;
        queue_random(200, 50, -1);
        wait_idle();
        repeat (10) @(posedge aclk);

        if (expected_slots.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_slots.size()));

        $display("Run covered %0d appends and %0d locates over %0d register writes.",
                 append_count, locate_count, write_count);
        $display("%0d results checked, including one %0d-cycle receiver hold-off.",
                 checked_count, LONG_HOLD);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
